// ===== hdl/gaps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gaps_pkg;

  // Map geometry. A cell index is {row, column}.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COORD_BITS = 6;
  localparam int CELL_BITS  = 12;
  localparam int NCELLS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_BITS   = CELL_BITS + 1;
  localparam int COST_BITS  = 24;
  localparam int DIM_BITS   = 7;
  localparam int SCALE_BITS = 8;
  localparam int DIST_BITS  = 7;
  localparam int HEUR_BITS  = DIST_BITS + SCALE_BITS;

  // Request kinds carried on s_tuser.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_STRAIGHT = 2'd2;
  localparam logic [1:0] REG_DIAG     = 2'd3;

  // Cell status codes.
  localparam logic [1:0] ST_UNSEEN = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_CLOSED = 2'd2;

  typedef logic [COST_BITS-1:0] cost_t;

  // Saturating cost addition.
  function automatic cost_t sat_add(input cost_t a, input cost_t b);
    logic [COST_BITS:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[COST_BITS] ? {COST_BITS{1'b1}} : s[COST_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gaps_heur.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Registered Manhattan heuristic: (|gx-px| + |gy-py|) * scale.
module gaps_heur
  import gaps_pkg::*;
(
  input  wire                    clk,
  input  wire [COORD_BITS-1:0]   px,
  input  wire [COORD_BITS-1:0]   py,
  input  wire [COORD_BITS-1:0]   gx,
  input  wire [COORD_BITS-1:0]   gy,
  input  wire [SCALE_BITS-1:0]   scale,
  output logic [HEUR_BITS-1:0]   heur
);

  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [DIST_BITS-1:0]  man_sum;

  // Distance along each axis, then their sum.
  always_comb begin
    ax      = (gx > px) ? (gx - px) : (px - gx);
    ay      = (gy > py) ? (gy - py) : (py - gy);
    man_sum = {1'b0, ax} + {1'b0, ay};
  end

  always_ff @(posedge clk) begin
    heur <= HEUR_BITS'(man_sum) * HEUR_BITS'(scale);
  end

endmodule

`default_nettype wire

// ===== hdl/grid_astar_path_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load op: the map write happens on acceptance. Read op: S_RD0, S_RD1 and S_RESP lead to the result register.
// Search op: a status clear over all cells, then per expanded cell an open-list scan, a close
// and removal shift of the later entries, and nine neighbor positions, each fetched and, when
// in the grid, evaluated; the path walk then follows one parent per path cell.
// One request at a time; a result waiting on m_tready holds the next result in S_RESP.
// Reset (synchronous, rst high) restores the control registers and sweeps the map free.
module grid_astar_path_search
  import gaps_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // cell_x, cell_y, blocked, start_x, start_y, goal_x, goal_y, step_index
  input  wire [55:0]  s_tdata,
  // op
  input  wire [1:0]   s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // found, path_length, step_x, step_y, step_valid
  output logic [31:0] m_tdata,
  input  wire         cfg_we,
  input  wire [1:0]   cfg_index,
  input  wire [7:0]   cfg_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLEAR  = 5'd1;
  localparam logic [4:0] S_INIT0  = 5'd2;
  localparam logic [4:0] S_INIT1  = 5'd3;
  localparam logic [4:0] S_SCAN   = 5'd4;
  localparam logic [4:0] S_CLOSE  = 5'd5;
  localparam logic [4:0] S_POPCHK = 5'd6;
  localparam logic [4:0] S_POPRD  = 5'd7;
  localparam logic [4:0] S_POPWR  = 5'd8;
  localparam logic [4:0] S_NISSUE = 5'd9;
  localparam logic [4:0] S_NEVAL  = 5'd10;
  localparam logic [4:0] S_PATH0  = 5'd11;
  localparam logic [4:0] S_PATH1  = 5'd12;
  localparam logic [4:0] S_WALK   = 5'd13;
  localparam logic [4:0] S_WALKW  = 5'd14;
  localparam logic [4:0] S_RD0    = 5'd15;
  localparam logic [4:0] S_RD1    = 5'd16;
  localparam logic [4:0] S_RESP   = 5'd17;

  // Configuration registers.
  logic [DIM_BITS-1:0]   grid_width, grid_height;
  logic [SCALE_BITS-1:0] straight_cost, diag_cost;
  logic [DIM_BITS-1:0]   w_eff, h_eff;

  // Control registers.
  logic [4:0]            state, state_next;
  logic                  clr_map, clr_map_next;
  logic [CELL_BITS-1:0]  clr_addr, clr_addr_next;
  logic [COORD_BITS-1:0] sx, sy, gx, gy, sx_next, sy_next, gx_next, gy_next;
  logic [CELL_BITS-1:0]  idx_q, idx_next;
  logic [CNT_BITS-1:0]   path_count, path_count_next;
  logic [CNT_BITS-1:0]   open_count, open_count_next;
  logic [CNT_BITS-1:0]   ri, ri_next;
  logic                  p1v, p1v_next, p2v, p2v_next;
  logic [CELL_BITS-1:0]  p1i, p1i_next, p2i, p2i_next, p2c, p2c_next;
  logic                  best_set, best_set_next;
  logic [CELL_BITS-1:0]  best_i, best_i_next, best_c, best_c_next;
  cost_t                 best_f, best_f_next;
  logic [CELL_BITS-1:0]  pj, pj_next;
  cost_t                 gc, gc_next;
  logic [1:0]            dx, dy, dx_next, dy_next;
  logic [CELL_BITS-1:0]  nc_q, nc_next;
  logic [SCALE_BITS-1:0] stepc_q, stepc_next;
  logic [CELL_BITS-1:0]  b, b_next;
  logic [CNT_BITS-1:0]   n, n_next;
  logic                  rv, rv_next;
  logic [COORD_BITS-1:0] step_x, step_y, step_x_next, step_y_next;
  logic                  step_valid, step_valid_next;
  logic                  m_tvalid_next;
  logic [31:0]           m_tdata_next;

  // Memory ports.
  logic                  obs_we, obs_re, obs_wd, obs_rd;
  logic [CELL_BITS-1:0]  obs_wa, obs_ra;
  logic                  st_we, st_re;
  logic [1:0]            st_wd, st_rd;
  logic [CELL_BITS-1:0]  st_wa, st_ra;
  logic                  g_we, g_re;
  cost_t                 g_wd, g_rd;
  logic [CELL_BITS-1:0]  g_wa, g_ra;
  logic                  f_we, f_re;
  cost_t                 f_wd, f_rd;
  logic [CELL_BITS-1:0]  f_wa, f_ra;
  logic                  par_we, par_re;
  logic [CELL_BITS-1:0]  par_wd, par_rd, par_wa, par_ra;
  logic                  opn_we, opn_re;
  logic [CELL_BITS-1:0]  opn_wd, opn_rd, opn_wa, opn_ra;
  logic                  pth_we, pth_re;
  logic [CELL_BITS-1:0]  pth_wd, pth_rd, pth_wa, pth_ra;

  logic                  obs_mem [NCELLS];
  logic [1:0]            st_mem  [NCELLS];
  cost_t                 g_mem   [NCELLS];
  cost_t                 f_mem   [NCELLS];
  logic [CELL_BITS-1:0]  par_mem [NCELLS];
  logic [CELL_BITS-1:0]  opn_mem [NCELLS];
  logic [CELL_BITS-1:0]  pth_mem [NCELLS];

  // Heuristic unit.
  logic [COORD_BITS-1:0] hx, hy;
  logic [HEUR_BITS-1:0]  heur;

  // Neighbor arithmetic.
  logic [COORD_BITS-1:0] cx, cy, nx, ny;
  logic [DIM_BITS:0]     nxs, nys;
  logic                  nb_ok, nb_last;
  cost_t                 newg;
  logic                  upd;
  logic                  accept;

  gaps_heur u_heur (
    .clk   (clk),
    .px    (hx),
    .py    (hy),
    .gx    (gx),
    .gy    (gy),
    .scale (straight_cost),
    .heur  (heur)
  );

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (obs_we) obs_mem[obs_wa] <= obs_wd;
    if (obs_re) obs_rd <= obs_mem[obs_ra];
    if (st_we) st_mem[st_wa] <= st_wd;
    if (st_re) st_rd <= st_mem[st_ra];
    if (g_we) g_mem[g_wa] <= g_wd;
    if (g_re) g_rd <= g_mem[g_ra];
    if (f_we) f_mem[f_wa] <= f_wd;
    if (f_re) f_rd <= f_mem[f_ra];
    if (par_we) par_mem[par_wa] <= par_wd;
    if (par_re) par_rd <= par_mem[par_ra];
    if (opn_we) opn_mem[opn_wa] <= opn_wd;
    if (opn_re) opn_rd <= opn_mem[opn_ra];
    if (pth_we) pth_mem[pth_wa] <= pth_wd;
    if (pth_re) pth_rd <= pth_mem[pth_ra];
  end

  // Grid size in use, clamped to the map.
  always_comb begin
    if (grid_width == '0) w_eff = DIM_BITS'(1);
    else if (grid_width > DIM_BITS'(MAX_WIDTH)) w_eff = DIM_BITS'(MAX_WIDTH);
    else w_eff = grid_width;
    if (grid_height == '0) h_eff = DIM_BITS'(1);
    else if (grid_height > DIM_BITS'(MAX_HEIGHT)) h_eff = DIM_BITS'(MAX_HEIGHT);
    else h_eff = grid_height;
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Current neighbor of the expanded cell.
  always_comb begin
    cx      = best_c[COORD_BITS-1:0];
    cy      = best_c[CELL_BITS-1:COORD_BITS];
    nxs     = {2'b00, cx} + {6'b0, dx};
    nys     = {2'b00, cy} + {6'b0, dy};
    nx      = COORD_BITS'(nxs - 8'd1);
    ny      = COORD_BITS'(nys - 8'd1);
    nb_ok   = (nxs != '0) && (nxs <= {1'b0, w_eff}) && (nys != '0) &&
              (nys <= {1'b0, h_eff}) && !(dx == 2'd1 && dy == 2'd1);
    nb_last = (dx == 2'd2) && (dy == 2'd2);
    newg    = sat_add(gc, COST_BITS'(stepc_q));
    upd     = (st_rd == ST_UNSEEN) || (newg < g_rd);
  end

  // Sequencer.
  always_comb begin
    state_next      = state;
    clr_map_next    = clr_map;
    clr_addr_next   = clr_addr;
    sx_next = sx; sy_next = sy; gx_next = gx; gy_next = gy;
    idx_next        = idx_q;
    path_count_next = path_count;
    open_count_next = open_count;
    ri_next = ri; p1v_next = 1'b0; p2v_next = p1v;
    p1i_next = p1i; p2i_next = p1i; p2c_next = opn_rd;
    best_set_next = best_set; best_i_next = best_i;
    best_c_next = best_c; best_f_next = best_f;
    pj_next = pj; gc_next = gc; dx_next = dx; dy_next = dy;
    nc_next = nc_q; stepc_next = stepc_q; b_next = b; n_next = n; rv_next = rv;
    step_x_next = step_x; step_y_next = step_y; step_valid_next = step_valid;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    hx = nx; hy = ny;
    obs_we = 1'b0; obs_wa = s_tdata[11:0]; obs_wd = s_tdata[12];
    obs_re = 1'b0; obs_ra = {ny, nx};
    st_we = 1'b0; st_wa = clr_addr; st_wd = ST_UNSEEN;
    st_re = 1'b0; st_ra = {ny, nx};
    g_we = 1'b0; g_wa = nc_q; g_wd = newg; g_re = 1'b0; g_ra = {ny, nx};
    f_we = 1'b0; f_wa = nc_q; f_wd = sat_add(newg, COST_BITS'(heur));
    f_re = 1'b0; f_ra = opn_rd;
    par_we = 1'b0; par_wa = nc_q; par_wd = best_c; par_re = 1'b0; par_ra = b;
    opn_we = 1'b0; opn_wa = open_count[CELL_BITS-1:0]; opn_wd = nc_q;
    opn_re = 1'b0; opn_ra = ri[CELL_BITS-1:0];
    pth_we = 1'b0; pth_wa = n[CELL_BITS-1:0]; pth_wd = b;
    pth_re = 1'b0;
    pth_ra = CELL_BITS'(path_count - CNT_BITS'(1) - {1'b0, idx_q});

    case (state)
      // Wait for a request; loads finish here.
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            OP_LOAD: obs_we = 1'b1;
            OP_SEARCH: begin
              sx_next = s_tdata[18:13]; sy_next = s_tdata[24:19];
              gx_next = s_tdata[30:25]; gy_next = s_tdata[36:31];
              path_count_next = '0;
              open_count_next = '0;
              step_x_next = '0; step_y_next = '0; step_valid_next = 1'b0;
              clr_addr_next = '0;
              state_next = S_CLEAR;
            end
            OP_READ: begin
              idx_next = s_tdata[48:37];
              state_next = S_RD0;
            end
            default: ;
          endcase
        end
      end

      // Status sweep, and the obstacle map too after reset.
      S_CLEAR: begin
        st_we = 1'b1;
        if (clr_map) begin
          obs_we = 1'b1; obs_wa = clr_addr; obs_wd = 1'b0;
        end
        clr_addr_next = clr_addr + CELL_BITS'(1);
        if (clr_addr == CELL_BITS'(NCELLS - 1)) begin
          clr_map_next = 1'b0;
          state_next = clr_map ? S_IDLE : S_INIT0;
        end
      end

      // Check end points and start the heuristic of the start cell.
      S_INIT0: begin
        hx = sx; hy = sy;
        if ({1'b0, sx} >= w_eff || {1'b0, sy} >= h_eff || {1'b0, gx} >= w_eff ||
            {1'b0, gy} >= h_eff || (sx == gx && sy == gy)) begin
          state_next = S_RESP;
        end else begin
          state_next = S_INIT1;
        end
      end

      // Seed the open list with the start cell.
      S_INIT1: begin
        g_we = 1'b1; g_wa = {sy, sx}; g_wd = '0;
        f_we = 1'b1; f_wa = {sy, sx}; f_wd = COST_BITS'(heur);
        opn_we = 1'b1; opn_wa = '0; opn_wd = {sy, sx};
        open_count_next = CNT_BITS'(1);
        ri_next = '0; best_set_next = 1'b0;
        state_next = S_SCAN;
      end

      // Pipelined scan for the first strict minimum of total score.
      S_SCAN: begin
        if (ri < open_count) begin
          opn_re = 1'b1;
          p1v_next = 1'b1;
          p1i_next = ri[CELL_BITS-1:0];
          ri_next = ri + CNT_BITS'(1);
        end
        f_re = p1v;
        if (p2v && (!best_set || f_rd < best_f)) begin
          best_set_next = 1'b1;
          best_i_next = p2i; best_c_next = p2c; best_f_next = f_rd;
        end
        if (ri >= open_count && !p1v && !p2v) state_next = S_CLOSE;
      end

      // Close the chosen cell and fetch its path cost.
      S_CLOSE: begin
        st_we = 1'b1; st_wa = best_c; st_wd = ST_CLOSED;
        g_re = 1'b1; g_ra = best_c;
        pj_next = best_i;
        state_next = S_POPCHK;
      end

      // Shift the later open entries down by one.
      S_POPCHK: begin
        gc_next = g_rd;
        if ({1'b0, pj} + CNT_BITS'(1) < open_count) begin
          state_next = S_POPRD;
        end else begin
          open_count_next = open_count - CNT_BITS'(1);
          dx_next = '0; dy_next = '0;
          state_next = S_NISSUE;
        end
      end

      S_POPRD: begin
        opn_re = 1'b1; opn_ra = pj + CELL_BITS'(1);
        state_next = S_POPWR;
      end

      S_POPWR: begin
        opn_we = 1'b1; opn_wa = pj; opn_wd = opn_rd;
        pj_next = pj + CELL_BITS'(1);
        state_next = S_POPCHK;
      end

      // Fetch one neighbor in x-major order, or skip it.
      S_NISSUE: begin
        if (nb_ok) begin
          obs_re = 1'b1; st_re = 1'b1; g_re = 1'b1;
          nc_next = {ny, nx};
          stepc_next = (dx == 2'd1 || dy == 2'd1) ? straight_cost : diag_cost;
          state_next = S_NEVAL;
        end else if (nb_last) begin
          ri_next = '0; best_set_next = 1'b0;
          state_next = (open_count == '0) ? S_PATH0 : S_SCAN;
        end else begin
          dx_next = (dy == 2'd2) ? dx + 2'd1 : dx;
          dy_next = (dy == 2'd2) ? 2'd0 : dy + 2'd1;
        end
      end

      // Relax the neighbor; stop when it is the goal.
      S_NEVAL: begin
        state_next = S_NISSUE;
        if (!(st_rd == ST_CLOSED || obs_rd)) begin
          if (st_rd == ST_UNSEEN) begin
            opn_we = 1'b1;
            open_count_next = open_count + CNT_BITS'(1);
            st_we = 1'b1; st_wa = nc_q; st_wd = ST_OPEN;
          end
          if (upd) begin
            g_we = 1'b1; f_we = 1'b1; par_we = 1'b1;
          end
        end
        if (!(st_rd == ST_CLOSED || obs_rd) && nc_q == {gy, gx}) begin
          state_next = S_PATH0;
        end else if (nb_last) begin
          ri_next = '0; best_set_next = 1'b0;
          state_next = (open_count_next == '0) ? S_PATH0 : S_SCAN;
        end else begin
          dx_next = (dy == 2'd2) ? dx + 2'd1 : dx;
          dy_next = (dy == 2'd2) ? 2'd0 : dy + 2'd1;
        end
      end

      // The goal has a parent exactly when it was ever opened.
      S_PATH0: begin
        st_re = 1'b1; st_ra = {gy, gx};
        state_next = S_PATH1;
      end

      S_PATH1: begin
        if (st_rd == ST_UNSEEN) begin
          state_next = S_RESP;
        end else begin
          b_next = {gy, gx}; n_next = '0;
          state_next = S_WALK;
        end
      end

      // Walk parents back to the start; the store holds the goal first.
      S_WALK: begin
        if (b == {sy, sx}) begin
          path_count_next = n;
          state_next = S_RESP;
        end else if (n[CELL_BITS]) begin
          state_next = S_RESP;
        end else begin
          pth_we = 1'b1;
          par_re = 1'b1;
          n_next = n + CNT_BITS'(1);
          state_next = S_WALKW;
        end
      end

      S_WALKW: begin
        b_next = par_rd;
        state_next = S_WALK;
      end

      // Path read.
      S_RD0: begin
        rv_next = ({1'b0, idx_q} < path_count);
        pth_re = ({1'b0, idx_q} < path_count);
        state_next = S_RD1;
      end

      S_RD1: begin
        step_valid_next = rv;
        step_x_next = rv ? pth_rd[COORD_BITS-1:0] : '0;
        step_y_next = rv ? pth_rd[CELL_BITS-1:COORD_BITS] : '0;
        state_next = S_RESP;
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next = {6'b0, step_valid, step_y, step_x,
                          path_count[CELL_BITS-1:0], (path_count != '0)};
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_map       <= 1'b1;
      clr_addr      <= '0;
      path_count    <= '0;
      open_count    <= '0;
      p1v           <= 1'b0;
      p2v           <= 1'b0;
      m_tvalid      <= 1'b0;
      grid_width    <= DIM_BITS'(64);
      grid_height   <= DIM_BITS'(64);
      straight_cost <= 8'd10;
      diag_cost     <= 8'd14;
    end else begin
      state      <= state_next;
      clr_map    <= clr_map_next;
      clr_addr   <= clr_addr_next;
      path_count <= path_count_next;
      open_count <= open_count_next;
      p1v        <= p1v_next;
      p2v        <= p2v_next;
      m_tvalid   <= m_tvalid_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:    grid_width    <= cfg_data[DIM_BITS-1:0];
          REG_HEIGHT:   grid_height   <= cfg_data[DIM_BITS-1:0];
          REG_STRAIGHT: straight_cost <= cfg_data;
          REG_DIAG:     diag_cost     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sx <= sx_next; sy <= sy_next; gx <= gx_next; gy <= gy_next;
    idx_q <= idx_next;
    ri <= ri_next; p1i <= p1i_next; p2i <= p2i_next; p2c <= p2c_next;
    best_set <= best_set_next; best_i <= best_i_next;
    best_c <= best_c_next; best_f <= best_f_next;
    pj <= pj_next; gc <= gc_next; dx <= dx_next; dy <= dy_next;
    nc_q <= nc_next; stepc_q <= stepc_next; b <= b_next; n <= n_next; rv <= rv_next;
    step_x <= step_x_next; step_y <= step_y_next; step_valid <= step_valid_next;
    m_tdata <= m_tdata_next;
  end

endmodule

`default_nettype wire

// ===== bench/tb_grid_astar_path_search.sv =====
`timescale 1ns / 1ps

module tb_grid_astar_path_search
  import gaps_pkg::*;
();

  localparam int WATCHDOG_CYCLES = 20000000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int NONE_CELL       = NCELLS;

  typedef struct packed {
    logic [1:0]  op;
    logic [55:0] data;
  } request_t;

  // Declared from the highest bit down, so found lands in bit 0.
  typedef struct packed {
    logic        step_valid;
    logic [5:0]  step_y;
    logic [5:0]  step_x;
    logic [11:0] path_length;
    logic        found;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  grid_astar_path_search i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  request_t pending_reqs[$];
  answer_t  answers_due[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_trigger = 0;
  int       hold_seen = 0;
  int       hold_cnt = 0;
  longint   cycle_cnt = 0;

  // Shadow copy of the block's registers and memories.
  int unsigned cols_reg, rows_reg, straight_reg, diag_reg;
  bit          obst_map[NCELLS];
  logic [1:0]  status_mem[NCELLS];
  longint      gcost_mem[NCELLS];
  longint      fscore_mem[NCELLS];
  int          parent_mem[NCELLS];
  int          open_mem[NCELLS];
  int          open_len;
  int          route_mem[NCELLS];
  int          route_len;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint clamp_cost(longint v);
    return (v > (64'd1 << COST_BITS) - 1) ? (64'd1 << COST_BITS) - 1 : v;
  endfunction

  function automatic int dist_of(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Append one request to the pending queue.
  task automatic queue_req(request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // A* search over the shadow map; fills the route store.
  task automatic astar_search(int sx, int sy, int gx, int gy);
    int w, h, s, g, i, best, c, cx, cy, nx, ny, nc, n, b;
    bit stop, upd;
    longint stepc, newg;
    w = (cols_reg == 0) ? 1 : ((cols_reg > MAX_WIDTH) ? MAX_WIDTH : cols_reg);
    h = (rows_reg == 0) ? 1 : ((rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : rows_reg);
    for (i = 0; i < NCELLS; i++) begin
      status_mem[i] = ST_UNSEEN;
      parent_mem[i] = NONE_CELL;
    end
    open_len = 0;
    route_len = 0;
    if (sx >= w || sy >= h || gx >= w || gy >= h || (sx == gx && sy == gy)) return;
    s = sy * MAX_WIDTH + sx;
    g = gy * MAX_WIDTH + gx;
    gcost_mem[s] = 0;
    fscore_mem[s] = clamp_cost(longint'(dist_of(gx, sx) + dist_of(gy, sy)) * straight_reg);
    open_mem[0] = s;
    open_len = 1;
    while (open_len > 0) begin
      best = 0;
      stop = 0;
      for (i = 1; i < open_len; i++)
        if (fscore_mem[open_mem[i]] < fscore_mem[open_mem[best]]) best = i;
      c = open_mem[best];
      for (i = best; i < open_len - 1; i++) open_mem[i] = open_mem[i + 1];
      open_len--;
      status_mem[c] = ST_CLOSED;
      cx = c % MAX_WIDTH;
      cy = c / MAX_WIDTH;
      for (int dx = 0; dx < 3 && !stop; dx++) begin
        nx = cx - 1 + dx;
        if (nx < 0 || nx >= w) continue;
        for (int dy = 0; dy < 3 && !stop; dy++) begin
          ny = cy - 1 + dy;
          if ((dx == 1 && dy == 1) || ny < 0 || ny >= h) continue;
          nc = ny * MAX_WIDTH + nx;
          if (status_mem[nc] == ST_CLOSED || obst_map[nc]) continue;
          stepc = (dx == 1 || dy == 1) ? straight_reg : diag_reg;
          newg = clamp_cost(gcost_mem[c] + stepc);
          upd = 0;
          if (status_mem[nc] == ST_UNSEEN) begin
            if (open_len < NCELLS) open_mem[open_len++] = nc;
            status_mem[nc] = ST_OPEN;
            upd = 1;
          end else if (newg < gcost_mem[nc]) begin
            upd = 1;
          end
          if (upd) begin
            gcost_mem[nc] = newg;
            fscore_mem[nc] = clamp_cost(newg +
                longint'(dist_of(gx, nx) + dist_of(gy, ny)) * straight_reg);
            parent_mem[nc] = c;
          end
          if (nc == g) stop = 1;
        end
      end
      if (stop) open_len = 0;
    end
    if (parent_mem[g] == NONE_CELL) return;
    n = 0;
    b = g;
    while (b != s && b < NCELLS && n < NCELLS) begin
      n++;
      b = parent_mem[b];
    end
    if (b != s) return;
    b = g;
    for (i = n; i > 0; i--) begin
      route_mem[i - 1] = b;
      b = parent_mem[b];
    end
    route_len = n;
  endtask

  // Apply one accepted request to the shadow state and queue the answer of a search or read.
  task automatic predict_request(request_t r);
    answer_t a;
    int idx;
    if (r.op == OP_LOAD) begin
      obst_map[r.data[11:6] * MAX_WIDTH + r.data[5:0]] = r.data[12];
      return;
    end
    if (r.op != OP_SEARCH && r.op != OP_READ) return;
    if (r.op == OP_SEARCH) astar_search(r.data[18:13], r.data[24:19], r.data[30:25], r.data[36:31]);
    a = '0;
    a.found = (route_len > 0);
    a.path_length = route_len[11:0];
    idx = r.data[48:37];
    if (r.op == OP_READ && idx < route_len) begin
      a.step_x = 6'(route_mem[idx] % MAX_WIDTH);
      a.step_y = 6'(route_mem[idx] / MAX_WIDTH);
      a.step_valid = 1'b1;
    end
    answers_due.insert(answers_due.size(), a);
  endtask

  // Request driver: predicts on acceptance, then offers the next pending request.
  always @(posedge clk) begin
    if (s_tvalid && s_tready) predict_request('{op: s_tuser, data: s_tdata});
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= r.data;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Answer monitor.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      answer_t got, want;
      got = m_tdata[25:0];
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer %h", $realtime, got);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (got.found !== want.found || got.path_length !== want.path_length ||
            got.step_x !== want.step_x || got.step_y !== want.step_y ||
            got.step_valid !== want.step_valid) begin
          $display("%0t: mismatch expected found=%0d len=%0d x=%0d y=%0d v=%0d",
                   $realtime, want.found, want.path_length, want.step_x, want.step_y,
                   want.step_valid);
          $display("%0t:          actual   found=%0d len=%0d x=%0d y=%0d v=%0d",
                   $realtime, got.found, got.path_length, got.step_x, got.step_y,
                   got.step_valid);
          errors++;
        end
      end
    end
  end

  // Receiver stall control, with one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_cnt = 20000;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic request_t make_req(logic [1:0] op);
    request_t r;
    r.op = op;
    r.data = {7'd0, 17'($urandom), $urandom};
    return r;
  endfunction

  task automatic add_load(int x, int y, bit blk);
    request_t r;
    r = make_req(OP_LOAD);
    r.data[5:0] = 6'(x);
    r.data[11:6] = 6'(y);
    r.data[12] = blk;
    queue_req(r);
  endtask

  task automatic add_search(int sx, int sy, int gx, int gy);
    request_t r;
    r = make_req(OP_SEARCH);
    r.data[18:13] = 6'(sx);
    r.data[24:19] = 6'(sy);
    r.data[30:25] = 6'(gx);
    r.data[36:31] = 6'(gy);
    queue_req(r);
  endtask

  task automatic add_read(int idx);
    request_t r;
    r = make_req(OP_READ);
    r.data[48:37] = 12'(idx);
    queue_req(r);
  endtask

  // Wait until everything sent has been answered and the block has settled.
  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() > 0 || s_tvalid || answers_due.size() > 0 || hold_cnt > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges.
  task automatic write_regs(int w, int h, int sc, int dc);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_WIDTH; cfg_data <= 8'(w); cols_reg = w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT; cfg_data <= 8'(h); rows_reg = h;
    @(posedge clk);
    cfg_index <= REG_STRAIGHT; cfg_data <= 8'(sc); straight_reg = sc;
    @(posedge clk);
    cfg_index <= REG_DIAG; cfg_data <= 8'(dc); diag_reg = dc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  initial begin
    int w, h, sx, sy, gx, gy, span, cnt;
    cols_reg = 64; rows_reg = 64; straight_reg = 10; diag_reg = 14;
    for (int i = 0; i < NCELLS; i++) begin
      obst_map[i] = 0;
      status_mem[i] = ST_UNSEEN;
      parent_mem[i] = NONE_CELL;
    end
    open_len = 0;
    route_len = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, corner load, NOP op, read before any search.
    add_load(63, 63, 1);
    add_load(63, 63, 0);
    queue_req(make_req(OP_NOP));
    add_read(0);
    add_search(0, 0, 3, 2);
    add_read(0);
    add_read(2);
    add_read(3);
    add_read(4095);
    add_search(5, 5, 5, 5);
    drain();

    // Directed: small grid, bad end points, blocked goal and start, wall detour.
    write_regs(8, 8, 10, 14);
    add_search(63, 0, 1, 1);
    add_load(4, 4, 1);
    add_search(0, 0, 4, 4);
    add_search(4, 4, 0, 0);
    add_read(0);
    for (int y = 0; y < 4; y++) add_load(2, y, 1);
    add_search(0, 0, 5, 0);
    add_read(1);
    drain();

    // Directed: grid size extremes and cost extremes.
    write_regs(0, 127, 0, 255);
    add_search(0, 0, 0, 63);
    add_read(62);
    drain();
    write_regs(127, 1, 255, 0);
    add_search(0, 0, 63, 0);
    add_read(62);
    drain();

    // Random phases of loads, searches and reads.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) begin
        w = 64; h = 64;
        write_regs(64, 64, 10, 14);
      end else begin
        w = $urandom_range(2, 16);
        h = $urandom_range(2, 16);
        write_regs(w, h, $urandom_range(0, 255), $urandom_range(0, 255));
      end
      set_idling(ph % 4);
      // Long receiver hold-off while reads keep arriving.
      if (ph == 0) hold_trigger++;
      cnt = 0;
      while (cnt < 12) begin
        if ($urandom_range(99) < 70) begin
          span = (w == 64) ? 6 : 63;
          repeat ($urandom_range(1, 3)) begin
            add_load($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     $urandom_range(0, 3) == 0);
            cnt++;
          end
          sx = $urandom_range(0, w - 1);
          sy = $urandom_range(0, h - 1);
          gx = sx + $urandom_range(0, 2 * span) - span;
          gy = sy + $urandom_range(0, 2 * span) - span;
          gx = (gx < 0) ? 0 : ((gx >= w) ? w - 1 : gx);
          gy = (gy < 0) ? 0 : ((gy >= h) ? h - 1 : gy);
          if ($urandom_range(9) == 0) gx = $urandom_range(0, 63);
          add_search(sx, sy, gx, gy);
          cnt++;
          repeat ($urandom_range(1, 4)) begin
            add_read($urandom_range(0, 20));
            cnt++;
          end
        end else begin
          request_t r;
          r = make_req(2'($urandom_range(0, 3)));
          if (r.op == OP_SEARCH && w == 64) begin
            r.data[30:25] = r.data[18:13];
            r.data[36:31] = r.data[24:19] + 6'd1;
          end
          queue_req(r);
          cnt++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
